// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while the disable expression is true.
`define PFU_ASSERT_IMP(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while the disable expression is true.
`define PFU_ASSERT_NXT(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/pfu_pkg.sv
// ----------------------------------------------------------------------------
// pfu_pkg
// Types, constants and helper functions of the pixel unpack block.
// ----------------------------------------------------------------------------
`default_nettype none

package pfu_pkg;

    localparam int NUM_LANES  = 4;
    localparam int NUM_STAGES = 8;

    localparam logic [31:0] F32_ZERO = 32'h0000_0000;
    localparam logic [31:0] F32_ONE  = 32'h3F80_0000;

    // Normalizing divisors: the largest value of each 8-bit and 16-bit type.
    localparam logic [15:0] DIV_U8  = 16'd255;
    localparam logic [15:0] DIV_S8  = 16'd127;
    localparam logic [15:0] DIV_U16 = 16'd65535;
    localparam logic [15:0] DIV_S16 = 16'd32767;

    // Reciprocals rounded up, scaled by 2^42.
    localparam logic [35:0] RECIP_U8  = 36'(((64'd1 << 42) + 64'd254) / 64'd255);
    localparam logic [35:0] RECIP_S8  = 36'(((64'd1 << 42) + 64'd126) / 64'd127);
    localparam logic [35:0] RECIP_U16 = 36'(((64'd1 << 42) + 64'd65534) / 64'd65535);
    localparam logic [35:0] RECIP_S16 = 36'(((64'd1 << 42) + 64'd32766) / 64'd32767);

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_TYPE  = 2'd0,
        CFG_COUNT = 2'd1,
        CFG_NORM  = 2'd2,
        CFG_NONE  = 2'd3
    } t_cfg_index;

    typedef enum logic [2:0] {
        CT_U8   = 3'd0,
        CT_S8   = 3'd1,
        CT_U16  = 3'd2,
        CT_S16  = 3'd3,
        CT_U32  = 3'd4,
        CT_S32  = 3'd5,
        CT_HALF = 3'd6,
        CT_F32  = 3'd7
    } t_comp_type;

    // How a lane builds its result.
    typedef enum logic [1:0] {
        KIND_DIRECT = 2'd0,
        KIND_INT    = 2'd1,
        KIND_NORM   = 2'd2,
        KIND_RSVD   = 2'd3
    } t_kind;

    // Normalizing divisor select.
    typedef enum logic [1:0] {
        DEN_U8  = 2'd0,
        DEN_S8  = 2'd1,
        DEN_U16 = 2'd2,
        DEN_S16 = 2'd3
    } t_den;

    typedef struct packed {
        logic [63:0] pixel_high;
        logic [63:0] pixel_low;
    } t_pixel;

    typedef struct packed {
        logic [31:0] red;
        logic [31:0] green;
        logic [31:0] blue;
        logic [31:0] alpha;
        logic        status;
    } t_color;

    typedef struct packed {
        t_comp_type  ctype;
        logic        norm;
        logic        present;
        logic [31:0] dflt;
        logic [31:0] raw;
    } t_lane_in;

    function automatic logic [35:0] recip_of(input t_den d);
        logic [35:0] r;
        unique case (d)
            DEN_U8:  r = RECIP_U8;
            DEN_S8:  r = RECIP_S8;
            DEN_U16: r = RECIP_U16;
            DEN_S16: r = RECIP_S16;
            default: r = RECIP_U8;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] den_of(input t_den d);
        logic [15:0] r;
        unique case (d)
            DEN_U8:  r = DIV_U8;
            DEN_S8:  r = DIV_S8;
            DEN_U16: r = DIV_U16;
            DEN_S16: r = DIV_S16;
            default: r = DIV_U8;
        endcase
        return r;
    endfunction

    // Position of the highest set bit of a 16-bit word (0 when zero).
    function automatic logic [3:0] msb16(input logic [15:0] v);
        logic [3:0] p;
        p = 4'd0;
        for (int i = 0; i < 16; i++) begin
            if (v[i]) p = 4'(i);
        end
        return p;
    endfunction

    // Position of the highest set bit of a 36-bit word (0 when zero).
    function automatic logic [5:0] msb36(input logic [35:0] v);
        logic [5:0] p;
        p = 6'd0;
        for (int i = 0; i < 36; i++) begin
            if (v[i]) p = 6'(i);
        end
        return p;
    endfunction

    // Exact widening of a half-precision pattern.
    function automatic logic [31:0] half_to_f32(input logic [15:0] h);
        logic [31:0] r;
        logic [4:0]  ex;
        logic [9:0]  m;
        logic [3:0]  q;
        logic [9:0]  ms;
        ex = h[14:10];
        m  = h[9:0];
        q  = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (m[i]) q = 4'(i);
        end
        ms = 10'(m << (4'd10 - q));
        if (ex == 5'd0) begin
            if (m == 10'd0) begin
                r = {h[15], 31'd0};
            end else begin
                r = {h[15], 8'(8'd103 + 8'(q)), ms, 13'd0};
            end
        end else if (ex == 5'd31) begin
            r = {h[15], 8'hFF, m, 13'd0};
        end else begin
            r = {h[15], 8'(8'(ex) + 8'd112), m, 13'd0};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/pfu_lane.sv
// ----------------------------------------------------------------------------
// pfu_lane
// Eight-stage conversion pipeline of one colour component to float32.
// ----------------------------------------------------------------------------
`default_nettype none

module pfu_lane (
    input  wire logic                              i_clk,
    input  wire logic [pfu_pkg::NUM_STAGES-1:0]    i_en,
    input  wire pfu_pkg::t_lane_in                 i_lane,
    output logic [31:0]                            o_value
);
    import pfu_pkg::*;

    localparam int LAST = NUM_STAGES - 1;

    // Control carried along every stage.
    t_kind       r_kind [0:LAST-1];
    logic        r_neg  [0:LAST-1];
    logic [31:0] r_dir  [0:LAST-1];

    // Stage 0: decode of the raw component.
    t_kind       n_kind;
    logic        n_neg;
    logic [31:0] n_dir;
    logic [32:0] n_mag;
    t_den        n_den;
    logic [32:0] r_mag0;
    t_den        r_den0;

    always_comb begin
        n_neg = 1'b0;
        n_mag = 33'd0;
        n_den = DEN_U8;
        n_dir = i_lane.dflt;
        unique case (i_lane.ctype)
            CT_U8: begin
                n_mag = 33'(i_lane.raw[7:0]);
            end
            CT_S8: begin
                n_neg = i_lane.raw[7];
                n_mag = n_neg ? 33'(9'h100 - 9'(i_lane.raw[7:0])) : 33'(i_lane.raw[6:0]);
                n_den = DEN_S8;
            end
            CT_U16: begin
                n_mag = 33'(i_lane.raw[15:0]);
                n_den = DEN_U16;
            end
            CT_S16: begin
                n_neg = i_lane.raw[15];
                n_mag = n_neg ? 33'(17'h10000 - 17'(i_lane.raw[15:0]))
                              : 33'(i_lane.raw[14:0]);
                n_den = DEN_S16;
            end
            CT_U32: begin
                n_mag = 33'(i_lane.raw);
            end
            CT_S32: begin
                n_neg = i_lane.raw[31];
                n_mag = n_neg ? (33'h1_0000_0000 - 33'(i_lane.raw)) : 33'(i_lane.raw);
            end
            CT_HALF: begin
                if (i_lane.present) n_dir = half_to_f32(i_lane.raw[15:0]);
            end
            CT_F32: begin
                if (i_lane.present) n_dir = i_lane.raw;
            end
            default: begin
                n_dir = i_lane.dflt;
            end
        endcase
        if (!i_lane.present || i_lane.ctype == CT_HALF || i_lane.ctype == CT_F32) begin
            n_kind = KIND_DIRECT;
        end else if (i_lane.norm) begin
            n_kind = KIND_NORM;
        end else begin
            n_kind = KIND_INT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_kind[0] <= n_kind;
            r_neg[0]  <= n_neg;
            r_dir[0]  <= n_dir;
            r_mag0    <= n_mag;
            r_den0    <= n_den;
        end
        for (int k = 1; k < LAST; k++) begin
            if (i_en[k]) begin
                r_kind[k] <= r_kind[k-1];
                r_neg[k]  <= r_neg[k-1];
                r_dir[k]  <= r_dir[k-1];
            end
        end
    end

    // Stage 1: bring the 16-bit magnitude to a leading one at bit 15.
    logic [3:0]  n_msb1;
    logic [15:0] r_m1;
    logic [3:0]  r_s1;
    logic [32:0] r_mag1;
    t_den        r_den1;

    assign n_msb1 = msb16(r_mag0[15:0]);

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_s1   <= 4'd15 - n_msb1;
            r_m1   <= 16'(r_mag0[15:0] << (4'd15 - n_msb1));
            r_mag1 <= r_mag0;
            r_den1 <= r_den0;
        end
    end

    // Stage 2: multiply by the scaled reciprocal.
    logic [51:0] r_p2;
    logic [15:0] r_m2;
    logic [3:0]  r_s2;
    logic [32:0] r_mag2;
    t_den        r_den2;

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_p2   <= 52'(r_m1) * 52'(recip_of(r_den1));
            r_m2   <= r_m1;
            r_s2   <= r_s1;
            r_mag2 <= r_mag1;
            r_den2 <= r_den1;
        end
    end

    // Stage 3: quotient estimate times divisor, for the remainder check.
    logic [35:0] n_q3;
    logic [35:0] r_q3;
    logic [51:0] r_t3;
    logic [15:0] r_m3;
    logic [3:0]  r_s3;
    logic [32:0] r_mag3;
    t_den        r_den3;

    assign n_q3 = r_p2[51:16];

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_q3   <= n_q3;
            r_t3   <= 52'(n_q3) * 52'(den_of(r_den2));
            r_m3   <= r_m2;
            r_s3   <= r_s2;
            r_mag3 <= r_mag2;
            r_den3 <= r_den2;
        end
    end

    // Stage 4: correct the estimate by one and pick the significand to round.
    logic [52:0] n_diff4;
    logic [52:0] n_sum4;
    logic        n_low4;
    logic [35:0] r_x4;
    logic signed [6:0] r_e4;
    logic        r_st4;

    assign n_diff4 = 53'({r_m3, 26'd0}) - 53'(r_t3);
    assign n_sum4  = n_diff4 + 53'(den_of(r_den3));
    assign n_low4  = n_diff4[52];

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            if (r_kind[3] == KIND_NORM) begin
                r_x4  <= n_low4 ? (r_q3 - 36'd1) : r_q3;
                r_st4 <= n_low4 ? (n_sum4 != 53'd0) : (n_diff4 != 53'd0);
                r_e4  <= 7'sd0 - 7'sd26 - signed'(7'(r_s3));
            end else begin
                r_x4  <= 36'(r_mag3);
                r_st4 <= 1'b0;
                r_e4  <= 7'sd0;
            end
        end
    end

    // Stage 5: find the leading one.
    logic [5:0]  r_p5;
    logic        r_z5;
    logic [35:0] r_x5;
    logic signed [6:0] r_e5;
    logic        r_st5;

    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r_p5  <= msb36(r_x4);
            r_z5  <= (r_x4 == 36'd0);
            r_x5  <= r_x4;
            r_e5  <= r_e4;
            r_st5 <= r_st4;
        end
    end

    // Stage 6: shift the leading one to bit 35 and form the biased exponent.
    logic [8:0]  n_exp6;
    logic [35:0] r_y6;
    logic [7:0]  r_exp6;
    logic        r_z6;
    logic        r_st6;

    assign n_exp6 = 9'(r_p5) + 9'(signed'(r_e5)) + 9'd127;

    always_ff @(posedge i_clk) begin
        if (i_en[6]) begin
            r_y6   <= 36'(r_x5 << (6'd35 - r_p5));
            r_exp6 <= n_exp6[7:0];
            r_z6   <= r_z5;
            r_st6  <= r_st5;
        end
    end

    // Stage 7: round to nearest even and select the lane result.
    logic        n_up7;
    logic [30:0] n_mag7;
    logic [31:0] r_out7;

    assign n_up7  = r_y6[11] & ((|r_y6[10:0]) | r_st6 | r_y6[12]);
    assign n_mag7 = {r_exp6, r_y6[34:12]} + 31'(n_up7);

    always_ff @(posedge i_clk) begin
        if (i_en[LAST]) begin
            if (r_kind[LAST-1] == KIND_DIRECT) begin
                r_out7 <= r_dir[LAST-1];
            end else if (r_z6) begin
                r_out7 <= F32_ZERO;
            end else begin
                r_out7 <= {r_neg[LAST-1], n_mag7};
            end
        end
    end

    assign o_value = r_out7;

endmodule

`default_nettype wire

// File: rtl/pixel_format_unpack_to_float_top.sv
// ----------------------------------------------------------------------------
// pixel_format_unpack_to_float_top
// Unpacks one raw pixel into a four-channel float32 colour.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (i_valid, o_stall, i_pixel) carries 16 little-endian
//   pixel bytes per transfer. The output channel (o_valid, i_stall, o_color)
//   carries red, green, blue, alpha as float32 patterns plus a status bit.
//   Status 1 means normalized mode was set for a 32-bit, half or float type;
//   the colour is then (0, 0, 0, 1).
//   The configuration channel (i_cfg_valid, o_cfg_ready, i_cfg_index,
//   i_cfg_data) is always ready and should be written only while idle.
//   One pixel is accepted every cycle while the input is not stalled; it
//   passes through an eight-stage per-lane pipeline (decode, normalize,
//   reciprocal multiply, remainder check, correction, leading-one search,
//   shift, round), four lanes in parallel.
//   Each stage advances when it is empty or when the stage after it moves,
//   so bubbles close up while the receiver stalls; the input stalls only
//   when all eight stages hold items.
//   Synchronous reset empties the pipeline and restores type u8, count 4
//   and normalized mode.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pixel_format_unpack_to_float_top #(
    parameter int MAX_COMPONENTS = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire pfu_pkg::t_pixel    i_pixel,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output pfu_pkg::t_color         o_color,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [2:0]         i_cfg_data
);
    import pfu_pkg::*;

    localparam int LAST = NUM_STAGES - 1;

    // Configuration registers.
    t_comp_type r_ctype;
    logic [2:0] r_count;
    logic       r_norm;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctype <= CT_U8;
            r_count <= 3'd4;
            r_norm  <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_TYPE:  r_ctype <= t_comp_type'(i_cfg_data);
                CFG_COUNT: r_count <= i_cfg_data;
                CFG_NORM:  r_norm  <= i_cfg_data[0];
                default:   r_norm  <= r_norm;
            endcase
        end
    end

    // Per-stage advance: a stage moves when empty or when its successor moves.
    logic [NUM_STAGES-1:0] r_v;
    logic [NUM_STAGES-1:0] n_en;

    always_comb begin
        n_en[LAST] = !r_v[LAST] || !i_stall;
        for (int k = LAST - 1; k >= 0; k--) begin
            n_en[k] = !r_v[k] || n_en[k+1];
        end
    end

    assign o_stall = !n_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (n_en[0]) r_v[0] <= i_valid;
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (n_en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // Component count, status and per-lane raw extraction.
    logic [2:0]   n_cnt;
    logic         n_status;
    logic [127:0] n_bytes;
    t_lane_in     n_lane [NUM_LANES];

    assign n_cnt    = (r_count > 3'(MAX_COMPONENTS)) ? 3'(MAX_COMPONENTS) : r_count;
    assign n_status = r_norm && r_ctype[2];
    assign n_bytes  = {i_pixel.pixel_high, i_pixel.pixel_low};

    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            n_lane[i].ctype   = r_ctype;
            n_lane[i].norm    = r_norm;
            n_lane[i].present = !n_status && (3'(i) < n_cnt);
            n_lane[i].dflt    = (i == NUM_LANES - 1) ? F32_ONE : F32_ZERO;
            unique case (r_ctype)
                CT_U8, CT_S8:                 n_lane[i].raw = 32'(n_bytes[8*i +: 8]);
                CT_U16, CT_S16, CT_HALF:      n_lane[i].raw = 32'(n_bytes[16*i +: 16]);
                CT_U32, CT_S32, CT_F32:       n_lane[i].raw = n_bytes[32*i +: 32];
                default:                      n_lane[i].raw = 32'd0;
            endcase
        end
    end

    // Conversion lanes.
    logic [31:0] w_value [NUM_LANES];

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        pfu_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (n_en),
            .i_lane  (n_lane[g]),
            .o_value (w_value[g])
        );
    end

    // Status travels beside the lanes.
    logic r_status [NUM_STAGES];

    always_ff @(posedge i_clk) begin
        if (n_en[0]) r_status[0] <= n_status;
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (n_en[k]) r_status[k] <= r_status[k-1];
        end
    end

    assign o_valid        = r_v[LAST];
    assign o_color.red    = w_value[0];
    assign o_color.green  = w_value[1];
    assign o_color.blue   = w_value[2];
    assign o_color.alpha  = w_value[3];
    assign o_color.status = r_status[LAST];

    // An unsupported normalization gives the default colour.
    `PFU_ASSERT_IMP(a_status_default, i_clk, !i_rst_n,
        o_valid && o_color.status,
        o_color.red == F32_ZERO && o_color.green == F32_ZERO &&
        o_color.blue == F32_ZERO && o_color.alpha == F32_ONE)
    // The input is never stalled while the last stage is empty.
    `PFU_ASSERT_IMP(a_no_false_stall, i_clk, !i_rst_n, !r_v[LAST], !o_stall)
    // Reset empties every stage.
    `PFU_ASSERT_NXT(a_reset_empty, i_clk, 1'b0, !i_rst_n, r_v == '0)

endmodule

`default_nettype wire
